### rtl/cmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared types, codes and widths of the calibrated command interpolator.
// ----------------------------------------------------------------------------
package cmi_pkg;

	localparam int VALVES_DEF = 8;
	localparam int POINTS_DEF = 16;
	localparam int QUEUE_DEF  = 2;

	localparam int FUNC_W  = 2;
	localparam int VALVE_W = 4;
	localparam int IDX_W   = 4;
	localparam int KPA_W   = 13;
	localparam int MV_W    = 12;
	localparam int TOTAL_W = 5;
	localparam int GAIN_W  = 18;
	localparam int ROW_W   = KPA_W + MV_W;

	localparam int WANT_W = MV_W + GAIN_W;     // desired * gain, Q16
	localparam int PROD_W = WANT_W + MV_W;     // offset * command delta
	localparam int DIV_W  = PROD_W + 2;        // 2*m + span, with headroom
	localparam int FRAC_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_MIN = 2'd2;

	localparam logic              ENABLE_RST  = 1'b1;
	localparam logic [GAIN_W-1:0] GAIN_RST    = 18'd104858;
	localparam logic [KPA_W-1:0]  DEF_MIN_RST = 13'd0;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_APPLY = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VALVE_W-1:0] valve;
		logic               valve_ok;
		logic [IDX_W-1:0]   idx;
		logic [KPA_W-1:0]   kpa;
		logic [MV_W-1:0]    mv;     // row command or desired command
		logic [TOTAL_W-1:0] total;  // already clamped to POINTS
	} op_t;

	typedef struct packed {
		logic              enable;
		logic [GAIN_W-1:0] gain;
		logic [KPA_W-1:0]  default_min;
	} cfg_t;

endpackage

### rtl/calibrated_command_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_command_interpolator
// Per-valve piecewise linear correction of millivolt commands.
//
// Command channel (cmd_valid / cmd_stall): one beat per item. func selects a
// row write, a row count write or an apply; writes give no result beat.
// Result channel (res_valid / res_stall): one beat per apply item.
// The front classifies beats into a two-entry queue; the back runs one item
// at a time. A write completes as the back takes it from the queue. An apply
// for a valve without a table goes straight to the result; with calibration
// off or a clamp to the first row it ends after reading row 0, and a clamp to
// the last row ends after reading the last row. An interpolated apply scans
// rows 1 upward (1 to POINTS - 1 of them) from the table RAM, then does one
// multiply and a 12-step restoring divide; a flat segment ends after the scan,
// and a segment that rounds back to its lower row ends before the divide.
// At reset the row counts clear, so every valve passes commands through; the
// table rows hold nothing until written. When res_stall holds a result, the
// back waits with the next one finished, and the queue keeps taking beats
// until full, then cmd_stall rises. The user must make configuration writes
// (cfg_we) only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module calibrated_command_interpolator #(
	parameter int VALVES = cmi_pkg::VALVES_DEF,
	parameter int POINTS = cmi_pkg::POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cmi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cmi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [cmi_pkg::FUNC_W-1:0]    func,
	input  logic [cmi_pkg::VALVE_W-1:0]   valve,
	input  logic [cmi_pkg::IDX_W-1:0]     point_index,
	input  logic [cmi_pkg::KPA_W-1:0]     point_kpa,
	input  logic [cmi_pkg::MV_W-1:0]      point_mv,
	input  logic [cmi_pkg::TOTAL_W-1:0]   point_total,
	input  logic [cmi_pkg::MV_W-1:0]      desired_mv,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [cmi_pkg::MV_W-1:0]      command_mv,
	output logic                          calibrated,
	output logic [cmi_pkg::KPA_W-1:0]     min_kpa
);

	cmi_pkg::cfg_t cfg_q;
	cmi_pkg::op_t  push_op;
	cmi_pkg::op_t  head_op;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= cmi_pkg::ENABLE_RST;
			cfg_q.gain        <= cmi_pkg::GAIN_RST;
			cfg_q.default_min <= cmi_pkg::DEF_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cmi_pkg::CFG_ENABLE:  cfg_q.enable      <= cfg_data[0];
				cmi_pkg::CFG_GAIN:    cfg_q.gain        <= cfg_data;
				cmi_pkg::CFG_DEF_MIN: cfg_q.default_min <= cfg_data[cmi_pkg::KPA_W-1:0];
				default:              cfg_q             <= cfg_q;
			endcase
		end
	end

	cmi_front #(
		.VALVES(VALVES),
		.POINTS(POINTS)
	) u_front (
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.func       (func),
		.valve      (valve),
		.point_index(point_index),
		.point_kpa  (point_kpa),
		.point_mv   (point_mv),
		.point_total(point_total),
		.desired_mv (desired_mv),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_op       (push_op)
	);

	cmi_queue #(
		.DEPTH(cmi_pkg::QUEUE_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (head_op)
	);

	cmi_back #(
		.VALVES(VALVES),
		.POINTS(POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (head_op),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.command_mv(command_mv),
		.calibrated(calibrated),
		.min_kpa   (min_kpa)
	);

endmodule

### rtl/cmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cmi_ram #(
	parameter int WIDTH = cmi_pkg::ROW_W,
	parameter int DEPTH = cmi_pkg::VALVES_DEF * cmi_pkg::POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/cmi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_front
// Accepts command beats, drops writes that hit no table and beats of unknown
// function, clamps row counts and hands each remaining item to the queue.
// ----------------------------------------------------------------------------
module cmi_front #(
	parameter int VALVES = cmi_pkg::VALVES_DEF,
	parameter int POINTS = cmi_pkg::POINTS_DEF
) (
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [cmi_pkg::FUNC_W-1:0]  func,
	input  logic [cmi_pkg::VALVE_W-1:0] valve,
	input  logic [cmi_pkg::IDX_W-1:0]   point_index,
	input  logic [cmi_pkg::KPA_W-1:0]   point_kpa,
	input  logic [cmi_pkg::MV_W-1:0]    point_mv,
	input  logic [cmi_pkg::TOTAL_W-1:0] point_total,
	input  logic [cmi_pkg::MV_W-1:0]    desired_mv,
	input  logic                        q_full,
	output logic                        q_push,
	output cmi_pkg::op_t                q_op
);

	logic valve_ok;
	logic idx_ok;
	logic keep;

	always_comb begin
		valve_ok = {1'b0, valve} < (cmi_pkg::VALVE_W + 1)'(VALVES);
		idx_ok   = {1'b0, point_index} < (cmi_pkg::IDX_W + 1)'(POINTS);

		q_op.valve    = valve;
		q_op.valve_ok = valve_ok;
		q_op.idx      = point_index;
		q_op.kpa      = point_kpa;
		q_op.mv       = point_mv;
		q_op.total    = (point_total > cmi_pkg::TOTAL_W'(POINTS)) ?
		                cmi_pkg::TOTAL_W'(POINTS) : point_total;
		q_op.kind     = cmi_pkg::OP_WRITE;
		keep          = 1'b0;

		case (func)
			cmi_pkg::FUNC_WRITE: begin
				keep = valve_ok && idx_ok;
			end
			cmi_pkg::FUNC_COUNT: begin
				q_op.kind = cmi_pkg::OP_COUNT;
				keep      = valve_ok;
			end
			cmi_pkg::FUNC_APPLY: begin
				q_op.kind = cmi_pkg::OP_APPLY;
				q_op.mv   = desired_mv;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd_stall = q_full;
	assign q_push    = cmd_valid && !q_full && keep;

endmodule

### rtl/cmi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cmi_queue #(
	parameter int DEPTH = cmi_pkg::QUEUE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cmi_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output cmi_pkg::op_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmi_pkg::op_t   mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with pointers apart");

endmodule

### rtl/cmi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_back
// Executes queued items: table writes, row counts, and the apply sequence
// (row scan, interpolation multiply, restoring divide) into a result register.
// ----------------------------------------------------------------------------
module cmi_back #(
	parameter int VALVES = cmi_pkg::VALVES_DEF,
	parameter int POINTS = cmi_pkg::POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmi_pkg::cfg_t             cfg,
	input  logic                      q_valid,
	input  cmi_pkg::op_t              q_head,
	output logic                      q_pop,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [cmi_pkg::MV_W-1:0]  command_mv,
	output logic                      calibrated,
	output logic [cmi_pkg::KPA_W-1:0] min_kpa
);

	localparam int DEPTH = VALVES * POINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int VIW   = (VALVES > 1) ? $clog2(VALVES) : 1;
	localparam int KW    = cmi_pkg::KPA_W;
	localparam int MW    = cmi_pkg::MV_W;
	localparam int TW    = cmi_pkg::TOTAL_W;
	localparam int WW    = cmi_pkg::WANT_W;
	localparam int PW    = cmi_pkg::PROD_W;
	localparam int DW    = cmi_pkg::DIV_W;
	localparam int FW    = cmi_pkg::FRAC_W;
	localparam int CNT_W = $clog2(MW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD0  = 3'd1;
	localparam logic [2:0] S_RDL  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_PREP = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [TW-1:0]              count_q [VALVES];
	logic                       res_valid_q;

	logic [cmi_pkg::VALVE_W-1:0] valve_q;
	logic [WW-1:0]              want_q;
	logic [TW-1:0]              n_q;
	logic [TW-1:0]              row_q;
	logic [KW-1:0]              prev_p_q;
	logic [MW-1:0]              prev_c_q;
	logic [KW-1:0]              span_q;
	logic [WW-1:0]              d_q;
	logic [MW-1:0]              adc_q;
	logic                       neg_q;
	logic [PW-1:0]              m_q;
	logic [DW-1:0]              rem_q;
	logic [DW-1:0]              den_q;
	logic [MW-1:0]              quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [MW-1:0]              rcmd_q;
	logic                       rcal_q;
	logic [KW-1:0]              rmin_q;
	logic [MW-1:0]              cmd_q;
	logic                       cal_q;
	logic [KW-1:0]              minp_q;

	logic [TW-1:0]              head_cnt;
	logic                       head_tbl;
	logic                       out_free;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [AW-1:0]              ram_raddr;
	logic [cmi_pkg::ROW_W-1:0]  ram_rdata;
	logic [cmi_pkg::VALVE_W-1:0] valve_sel;
	logic [TW-1:0]              row_sel;
	logic [KW-1:0]              rd_kpa;
	logic [MW-1:0]              rd_mv;
	logic [WW-1:0]              rd_want;
	logic                       want_le;
	logic                       want_ge;
	logic                       flat;
	logic [DW-1:0]              two_m;
	logic [DW-1:0]              s_full;
	logic                       small_neg;
	logic                       ge;
	logic [MW-1:0]              quo_nxt;

	assign head_cnt  = count_q[q_head.valve[VIW-1:0]];
	assign head_tbl  = q_head.valve_ok && (head_cnt >= TW'(2));
	assign out_free  = !res_valid_q || !res_stall;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	assign ram_we    = q_pop && (q_head.kind == cmi_pkg::OP_WRITE);
	assign ram_waddr = AW'(q_head.valve * POINTS) + AW'(q_head.idx);

	assign rd_kpa    = ram_rdata[cmi_pkg::ROW_W-1:MW];
	assign rd_mv     = ram_rdata[MW-1:0];
	assign rd_want   = {1'b0, rd_kpa, {FW{1'b0}}};
	assign want_le   = want_q <= rd_want;
	assign want_ge   = want_q >= rd_want;
	assign flat      = rd_kpa <= prev_p_q;

	assign two_m     = {1'b0, m_q, 1'b0};
	assign s_full    = DW'({span_q, {FW{1'b0}}});
	assign small_neg = neg_q && (two_m <= s_full);
	assign ge        = rem_q >= den_q;
	assign quo_nxt   = {quo_q[MW-2:0], ge};

	// read address: row 0 first, then the last row, then rows 1 upward
	always_comb begin
		case (state_q)
			S_IDLE: begin
				valve_sel = q_head.valve;
				row_sel   = '0;
			end
			S_RD0: begin
				valve_sel = valve_q;
				row_sel   = n_q - 1'b1;
			end
			S_RDL: begin
				valve_sel = valve_q;
				row_sel   = TW'(1);
			end
			S_SCAN: begin
				valve_sel = valve_q;
				row_sel   = row_q + 1'b1;
			end
			default: begin
				valve_sel = valve_q;
				row_sel   = '0;
			end
		endcase
		ram_raddr = AW'(valve_sel * POINTS) + AW'(row_sel);
	end

	cmi_ram #(
		.WIDTH(cmi_pkg::ROW_W),
		.DEPTH(DEPTH)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({q_head.kpa, q_head.mv}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_head.kind == cmi_pkg::OP_APPLY) begin
					state_d = head_tbl ? S_RD0 : S_DONE;
				end
			end
			S_RD0:   state_d = (!cfg.enable || want_le) ? S_DONE : S_RDL;
			S_RDL:   state_d = want_ge ? S_DONE : S_SCAN;
			S_SCAN: begin
				if (want_le) begin
					state_d = flat ? S_DONE : S_MUL;
				end
			end
			S_MUL:   state_d = S_PREP;
			S_PREP:  state_d = small_neg ? S_DONE : S_DIV;
			S_DIV:   state_d = (cnt_q == '0) ? S_DONE : S_DIV;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			for (int v = 0; v < VALVES; v++) begin
				count_q[v] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (q_pop && q_head.kind == cmi_pkg::OP_COUNT) begin
				count_q[q_head.valve[VIW-1:0]] <= q_head.total;
			end
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				valve_q <= q_head.valve;
				want_q  <= WW'(q_head.mv) * WW'(cfg.gain);
				n_q     <= head_cnt;
				rcmd_q  <= q_head.mv;
				rcal_q  <= 1'b0;
				rmin_q  <= cfg.default_min;
			end
			S_RD0: begin
				rmin_q   <= rd_kpa;
				prev_p_q <= rd_kpa;
				prev_c_q <= rd_mv;
				if (cfg.enable && want_le) begin
					rcmd_q <= rd_mv;
					rcal_q <= 1'b1;
				end else if (cfg.enable) begin
					rcal_q <= 1'b1;
				end
			end
			S_RDL: begin
				row_q <= TW'(1);
				if (want_ge) begin
					rcmd_q <= rd_mv;
				end
			end
			S_SCAN: begin
				if (want_le) begin
					rcmd_q <= rd_mv;
					span_q <= rd_kpa - prev_p_q;
					d_q    <= want_q - {1'b0, prev_p_q, {FW{1'b0}}};
					neg_q  <= rd_mv < prev_c_q;
					adc_q  <= (rd_mv < prev_c_q) ? prev_c_q - rd_mv : rd_mv - prev_c_q;
				end else begin
					prev_p_q <= rd_kpa;
					prev_c_q <= rd_mv;
					row_q    <= row_q + 1'b1;
				end
			end
			S_MUL: begin
				m_q <= PW'(d_q) * PW'(adc_q);
			end
			S_PREP: begin
				// round half up; a negative numerator truncates toward zero
				rcmd_q <= prev_c_q;
				rem_q  <= neg_q ? two_m - s_full : two_m + s_full;
				den_q  <= DW'({span_q, {(FW + MW){1'b0}}});
				quo_q  <= '0;
				cnt_q  <= CNT_W'(MW - 1);
			end
			S_DIV: begin
				if (ge) begin
					rem_q <= rem_q - den_q;
				end
				den_q <= den_q >> 1;
				quo_q <= quo_nxt;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					rcmd_q <= neg_q ? prev_c_q - quo_nxt : prev_c_q + quo_nxt;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd_q  <= rcmd_q;
					cal_q  <= rcal_q;
					minp_q <= rmin_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign res_valid  = res_valid_q;
	assign command_mv = cmd_q;
	assign calibrated = cal_q;
	assign min_kpa    = minp_q;

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> row_q < n_q)
		else $error("row scan ran past the last row");

	a_table_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD0 |-> n_q >= TW'(2))
		else $error("table lookup on a valve with fewer than two rows");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < {den_q[DW-2:0], 1'b0})
		else $error("divide remainder out of range, quotient would overflow");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the done state");

endmodule

### tb/sv/tb_calibrated_command_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calibrated_command_interpolator
// Self-checking bench for the per-valve command interpolator. Beats go in
// through the command channel with random gaps. Each accepted beat updates a
// mirror of the row tables and the registers. Each apply beat queues the
// corrected command that the mirror predicts, and every result beat is
// checked against the oldest queued correction. Directed tests cover pass
// through, ignored beats, a full table and register extremes. Random table
// loads and noise follow under several register settings.
// ----------------------------------------------------------------------------
module tb_calibrated_command_interpolator;
	import cmi_pkg::*;

	localparam int VALVES        = VALVES_DEF;
	localparam int POINTS        = POINTS_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT   = 3000;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALVE_W-1:0] valve;
		logic [IDX_W-1:0]   idx;
		logic [KPA_W-1:0]   kpa;
		logic [MV_W-1:0]    mv;
		logic [TOTAL_W-1:0] total;
		logic [MV_W-1:0]    desired;
	} cmd_beat_t;

	typedef struct packed {
		logic [MV_W-1:0]  command;
		logic             calibrated;
		logic [KPA_W-1:0] floor_kpa;
	} correction_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 cmd_valid;
	logic                 cmd_stall;
	logic [FUNC_W-1:0]    func;
	logic [VALVE_W-1:0]   valve;
	logic [IDX_W-1:0]     point_index;
	logic [KPA_W-1:0]     point_kpa;
	logic [MV_W-1:0]      point_mv;
	logic [TOTAL_W-1:0]   point_total;
	logic [MV_W-1:0]      desired_mv;
	logic                 res_valid;
	logic                 res_stall;
	logic [MV_W-1:0]      command_mv;
	logic                 calibrated;
	logic [KPA_W-1:0]     min_kpa;

	// mirror of the block
	logic [KPA_W-1:0]   mirror_kpa [VALVES*POINTS];
	logic [MV_W-1:0]    mirror_mv [VALVES*POINTS];
	bit                 row_loaded [VALVES*POINTS];
	logic [TOTAL_W-1:0] mirror_count [VALVES];
	logic               mirror_enable;
	logic [GAIN_W-1:0]  mirror_gain;
	logic [KPA_W-1:0]   mirror_def_min;

	correction_t pending_corrections[$];
	int          error_count;
	int          beats_done;
	bit          quiet;
	bit          sender_idles;

	calibrated_command_interpolator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.func(func),
		.valve(valve),
		.point_index(point_index),
		.point_kpa(point_kpa),
		.point_mv(point_mv),
		.point_total(point_total),
		.desired_mv(desired_mv),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.command_mv(command_mv),
		.calibrated(calibrated),
		.min_kpa(min_kpa)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Interpolate the command for a wanted pressure (Q16, in 1/65536 kPa).
	function automatic logic [MV_W-1:0] interpolate_row(input int v, input longint want);
		int     base;
		int     n;
		int     i;
		longint p_lo;
		longint span;
		longint dc;
		longint num;
		longint den;
		base = v * POINTS;
		n = mirror_count[v];
		if (want <= (longint'(mirror_kpa[base]) << 16))
			return mirror_mv[base];
		if (want >= (longint'(mirror_kpa[base + n - 1]) << 16))
			return mirror_mv[base + n - 1];
		for (i = 1; i < n; i++) begin
			if (want <= (longint'(mirror_kpa[base + i]) << 16)) begin
				p_lo = longint'(mirror_kpa[base + i - 1]);
				span = longint'(mirror_kpa[base + i]) - p_lo;
				if (span <= 0)
					return mirror_mv[base + i];
				dc = longint'(mirror_mv[base + i]) - longint'(mirror_mv[base + i - 1]);
				num = 2 * (want - (p_lo << 16)) * dc + (span << 16);
				den = 2 * (span << 16);
				// signed division truncates toward zero
				return MV_W'(longint'(mirror_mv[base + i - 1]) + num / den);
			end
		end
		return mirror_mv[base + n - 1];
	endfunction

	// Advance the mirror by one beat; returns 1 when the beat yields a result.
	function automatic bit predict_correction(input cmd_beat_t b, output correction_t r);
		int     slot;
		bit     has_rows;
		longint want;
		r.command = b.desired;
		r.calibrated = 1'b0;
		r.floor_kpa = mirror_def_min;
		slot = int'(b.valve) * POINTS + int'(b.idx);
		case (b.func)
			FUNC_WRITE: begin
				if (b.valve < VALVES && b.idx < POINTS) begin
					mirror_kpa[slot] = b.kpa;
					mirror_mv[slot] = b.mv;
					row_loaded[slot] = 1'b1;
				end
				return 1'b0;
			end
			FUNC_COUNT: begin
				if (b.valve < VALVES)
					mirror_count[b.valve] = (b.total > POINTS) ? TOTAL_W'(POINTS) : b.total;
				return 1'b0;
			end
			FUNC_APPLY: begin
				has_rows = 1'b0;
				if (b.valve < VALVES)
					has_rows = (mirror_count[b.valve] >= 2);
				if (has_rows)
					r.floor_kpa = mirror_kpa[int'(b.valve) * POINTS];
				if (has_rows && mirror_enable) begin
					want = longint'(b.desired) * longint'(mirror_gain);
					r.command = interpolate_row(int'(b.valve), want);
					r.calibrated = 1'b1;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Pick a row count that never exposes an unwritten row.
	function automatic logic [TOTAL_W-1:0] safe_total(input int v);
		int w;
		w = 0;
		while (w < POINTS && row_loaded[v * POINTS + w])
			w++;
		if (w == POINTS && $urandom_range(0, 3) == 0)
			return TOTAL_W'($urandom_range(POINTS, 31));
		if (w >= 2 && $urandom_range(0, 2) != 0)
			return TOTAL_W'($urandom_range(2, w));
		return TOTAL_W'($urandom_range(0, 1));
	endfunction

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		b.func = FUNC_W'($urandom_range(0, 3));
		b.valve = VALVE_W'($urandom_range(0, 15));
		b.idx = IDX_W'($urandom_range(0, 15));
		b.kpa = KPA_W'($urandom_range(0, 8191));
		b.mv = MV_W'($urandom_range(0, 4095));
		b.total = TOTAL_W'($urandom_range(0, 31));
		b.desired = MV_W'($urandom_range(0, 4095));
		if (b.func == FUNC_COUNT && b.valve < VALVES)
			b.total = safe_total(int'(b.valve));
		return b;
	endfunction

	// Entered and left at a falling edge with cmd_valid low.
	task automatic send_beat(input cmd_beat_t b);
		correction_t r;
		if (sender_idles && !quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16)) @(negedge clk);
		cmd_valid = 1'b1;
		func = b.func;
		valve = b.valve;
		point_index = b.idx;
		point_kpa = b.kpa;
		point_mv = b.mv;
		point_total = b.total;
		desired_mv = b.desired;
		do @(posedge clk); while (cmd_stall);
		if (predict_correction(b, r))
			pending_corrections.push_back(r);
		if (b.func == FUNC_APPLY || (b.func != FUNC_NONE && b.valve < VALVES))
			beats_done++;
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic wait_drained(input bit settle);
		while (pending_corrections.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_settings(input logic en, input logic [GAIN_W-1:0] gain,
			input logic [KPA_W-1:0] floor_kpa);
		wait_drained(1'b1);
		put_register(CFG_ENABLE, CFG_W'(en));
		put_register(CFG_GAIN, CFG_W'(gain));
		put_register(CFG_DEF_MIN, CFG_W'(floor_kpa));
		mirror_enable = en;
		mirror_gain = gain;
		mirror_def_min = floor_kpa;
	endtask

	task automatic send_apply(input int v, input int d);
		cmd_beat_t b;
		b = random_beat();
		b.func = FUNC_APPLY;
		b.valve = VALVE_W'(v);
		b.desired = MV_W'(d);
		send_beat(b);
	endtask

	// Load rows 0..rows-1 of one valve, set its count, then apply a few commands.
	task automatic load_table(input int v, input int rows);
		cmd_beat_t b;
		int        kpa_of [POINTS];
		int        top;
		int        base_p;
		int        p;
		int        i;
		bit        jumble;
		longint    d;
		top = int'((longint'(4095) * longint'(mirror_gain)) >> 16);
		if (top > 8191)
			top = 8191;
		if (top < 64)
			top = 64;
		jumble = ($urandom_range(0, 7) == 0);
		base_p = $urandom_range(0, top / 4);
		p = base_p;
		for (i = 0; i < rows; i++) begin
			if (jumble)
				p = $urandom_range(0, 8191);
			else if (i > 0 && $urandom_range(0, 5) != 0)
				p = p + $urandom_range(1, 2 * (top - base_p) / rows + 1);
			if (p > 8191)
				p = 8191;
			kpa_of[i] = p;
			b = random_beat();
			b.func = FUNC_WRITE;
			b.valve = VALVE_W'(v);
			b.idx = IDX_W'(i);
			b.kpa = KPA_W'(p);
			send_beat(b);
		end
		b = random_beat();
		b.func = FUNC_COUNT;
		b.valve = VALVE_W'(v);
		b.total = TOTAL_W'(rows);
		if (rows == POINTS && $urandom_range(0, 1) == 0)
			b.total = TOTAL_W'($urandom_range(POINTS, 31));
		send_beat(b);
		repeat ($urandom_range(2, 8)) begin
			d = $urandom_range(0, 4095);
			if (mirror_gain != 0 && $urandom_range(0, 1) == 0) begin
				// aim near one row so interpolation and row hits dominate
				i = $urandom_range(0, rows - 1);
				d = (longint'(kpa_of[i]) << 16) / longint'(mirror_gain);
				d = d + longint'($urandom_range(0, 2)) - 1;
				if (d < 0)
					d = 0;
				if (d > 4095)
					d = 4095;
			end
			send_apply(v, int'(d));
		end
	endtask

	task automatic test_passthrough();
		cmd_beat_t b;
		send_apply(0, 4095);
		send_apply(15, 0);
		b = random_beat();
		b.func = FUNC_COUNT;
		b.valve = 4'd6;
		b.total = 5'd1;
		send_beat(b);
		send_apply(6, 2048);
	endtask

	task automatic test_ignored_beats();
		cmd_beat_t b;
		b = '{FUNC_WRITE, 4'd15, 4'd15, 13'd8191, 12'd4095, 5'd31, 12'd4095};
		send_beat(b);
		b = '{FUNC_COUNT, 4'd8, 4'd0, 13'd0, 12'd0, 5'd31, 12'd0};
		send_beat(b);
		b = '{FUNC_NONE, 4'd15, 4'd15, 13'd8191, 12'd4095, 5'd31, 12'd4095};
		send_beat(b);
	endtask

	// Valve 7 gets all rows: a flat pair, both pressure extremes, falling ends.
	task automatic test_full_table();
		cmd_beat_t b;
		int        i;
		for (i = 0; i < POINTS; i++) begin
			b = random_beat();
			b.func = FUNC_WRITE;
			b.valve = 4'd7;
			b.idx = IDX_W'(i);
			b.kpa = (i == POINTS - 1) ? 13'd8191 : KPA_W'((i == 6 ? 5 : i) * 546);
			b.mv = (i == 0) ? 12'd4095 : (i == POINTS - 1) ? 12'd0 : MV_W'(i * 273);
			send_beat(b);
		end
		b = random_beat();
		b.func = FUNC_COUNT;
		b.valve = 4'd7;
		b.total = 5'd31;
		send_beat(b);
		send_apply(7, 0);
		send_apply(7, 4095);
	endtask

	task automatic test_register_extremes();
		write_settings(1'b0, GAIN_RST, 13'd8191);
		send_apply(7, 4095);
		send_apply(0, 123);
		write_settings(1'b1, 18'h3FFFF, 13'd0);
		send_apply(7, 4095);
		send_apply(7, 1);
		write_settings(1'b1, 18'd0, 13'd0);
		send_apply(7, 4095);
		write_settings(ENABLE_RST, GAIN_RST, DEF_MIN_RST);
	endtask

	task automatic test_random_traffic(input int beats, input bit calm);
		int goal;
		int pick;
		quiet = calm;
		goal = beats_done + beats;
		while (beats_done < goal) begin
			if ($urandom_range(0, 31) == 0)
				sender_idles = !sender_idles;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				load_table($urandom_range(0, VALVES - 1),
					($urandom_range(0, 3) == 0) ? $urandom_range(2, POINTS) : $urandom_range(2, 5));
			else if (pick < 8)
				repeat ($urandom_range(1, 6)) send_beat(random_beat());
			else if (pick < 9)
				repeat ($urandom_range(1, 6)) send_apply($urandom_range(0, 15), $urandom_range(0, 4095));
			else
				wait_drained(1'b0); // hold the sender until every result is back
		end
	endtask

	initial begin : main
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		cmd_valid = 1'b0;
		func = FUNC_NONE;
		valve = '0;
		point_index = '0;
		point_kpa = '0;
		point_mv = '0;
		point_total = '0;
		desired_mv = '0;
		for (i = 0; i < VALVES * POINTS; i++)
			row_loaded[i] = 1'b0;
		for (i = 0; i < VALVES; i++)
			mirror_count[i] = '0;
		mirror_enable = ENABLE_RST;
		mirror_gain = GAIN_RST;
		mirror_def_min = DEF_MIN_RST;
		error_count = 0;
		beats_done = 0;
		quiet = 1'b0;
		sender_idles = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_passthrough();
		test_ignored_beats();
		test_full_table();
		test_register_extremes();
		test_random_traffic(250, 1'b0);
		write_settings(1'b1, GAIN_W'($urandom_range(0, 262143)), KPA_W'($urandom_range(0, 8191)));
		test_random_traffic(200, 1'b0);
		write_settings(1'b0, GAIN_W'($urandom_range(0, 262143)), KPA_W'($urandom_range(0, 8191)));
		test_random_traffic(100, 1'b0);
		write_settings(ENABLE_RST, GAIN_RST, KPA_W'($urandom_range(0, 8191)));
		test_random_traffic(200, 1'b1);

		wait_drained(1'b1);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side back-pressure: stall bursts between runs of free flow.
	initial begin : result_stall
		int hold;
		int run;
		hold = 0;
		run = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && run == 0) begin
				if ($urandom_range(0, 2) == 0)
					hold = $urandom_range(1, 16);
				else
					run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
			end
			if (hold > 0) begin
				res_stall = !quiet;
				hold--;
			end else begin
				res_stall = 1'b0;
				run--;
			end
		end
	end

	// Four-state compare so an unknown output never slips through.
	task automatic check_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		correction_t r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_corrections.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none, actual %0d",
					$time, command_mv);
				error_count++;
			end else begin
				r = pending_corrections.pop_front();
				check_field("command_mv", r.command, command_mv);
				check_field("calibrated", r.calibrated, calibrated);
				check_field("min_kpa", r.floor_kpa, min_kpa);
			end
		end
	end

	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				stale = 0;
			else
				stale++;
		end
		$display("%0t: no beat moved for %0d cycles, %0d results pending",
			$time, STALL_LIMIT, pending_corrections.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### calibrated_command_interpolator.f
rtl/cmi_pkg.sv
rtl/cmi_ram.sv
rtl/cmi_front.sv
rtl/cmi_queue.sv
rtl/cmi_back.sv
rtl/calibrated_command_interpolator.sv
tb/sv/tb_calibrated_command_interpolator.sv
